FILE: hw/rtl/utf8_to_utf16_utf32_transcoder_core_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 transcoder assertion macros
// Clocked assertion helpers shared by the transcoder queue and back.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_UTF32_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_UTF16_UTF32_TRANSCODER_CORE_MACROS_SVH

// check a property on every clock edge outside reset
`define U2U_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define U2U_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/u2u_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 transcoder package
// Shared types and constants of the transcoder front, queue and back.
// ----------------------------------------------------------------------------
package u2u_pkg;

  localparam int CP_W       = 21;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0]  REG_OUTPUT_FORMAT = 3'h0;
  localparam logic [15:0] HI_SURR_OFFSET    = 16'hD7C0;
  localparam logic [15:0] LO_SURR_OFFSET    = 16'hDC00;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CONT = 2'd1,
    ST_TRUNC    = 2'd2,
    ST_BAD_LEAD = 2'd3
  } status_t;

  typedef enum logic {
    FMT_UTF16 = 1'b0,
    FMT_UTF32 = 1'b1
  } fmt_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    status_t         st;
  } evt_t;

  typedef struct packed {
    logic valid;
    evt_t evt;
  } evt_push_t;

  typedef struct packed {
    logic empty;
    logic full;
    evt_t head;
  } queue_stat_t;

endpackage

FILE: hw/rtl/u2u_front.sv
// ----------------------------------------------------------------------------
// UTF-8 transcoder front
// Accepts text bytes, tracks open sequences and pushes decoded events.
// ----------------------------------------------------------------------------
module u2u_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output u2u_pkg::evt_push_t push
);

  logic [1:0]               rem_r, rem_nxt;
  logic [u2u_pkg::CP_W-1:0] part_r, part_nxt;
  logic [u2u_pkg::CP_W-1:0] cont;
  logic [1:0]               rem_dec;

  assign cont    = {part_r[u2u_pkg::CP_W-7:0], in_byte[5:0]};
  assign rem_dec = rem_r - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 2'd0;
      part_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  always_comb begin
    rem_nxt        = rem_r;
    part_nxt       = part_r;
    push.valid     = 1'b0;
    push.evt.cp    = '0;
    push.evt.st    = u2u_pkg::ST_OK;
    if (in_fire) begin
      if (rem_r == 2'd0) begin
        case (in_byte) inside
          [8'h00:8'h7F]: begin
            push.valid  = 1'b1;
            push.evt.cp = {{(u2u_pkg::CP_W-8){1'b0}}, in_byte};
          end
          [8'hC0:8'hDF]: begin
            rem_nxt  = 2'd1;
            part_nxt = {{(u2u_pkg::CP_W-5){1'b0}}, in_byte[4:0]};
          end
          [8'hE0:8'hEF]: begin
            rem_nxt  = 2'd2;
            part_nxt = {{(u2u_pkg::CP_W-4){1'b0}}, in_byte[3:0]};
          end
          [8'hF0:8'hF7]: begin
            rem_nxt  = 2'd3;
            part_nxt = {{(u2u_pkg::CP_W-3){1'b0}}, in_byte[2:0]};
          end
          default: begin
            push.valid  = 1'b1;
            push.evt.st = u2u_pkg::ST_BAD_LEAD;
          end
        endcase
        if (rem_nxt != 2'd0 && in_last) begin
          rem_nxt     = 2'd0;
          part_nxt    = '0;
          push.valid  = 1'b1;
          push.evt.st = u2u_pkg::ST_TRUNC;
        end
      end else if (in_byte[7:6] != 2'b10) begin
        rem_nxt     = 2'd0;
        part_nxt    = '0;
        push.valid  = 1'b1;
        push.evt.st = u2u_pkg::ST_BAD_CONT;
      end else if (rem_dec == 2'd0) begin
        rem_nxt     = 2'd0;
        part_nxt    = '0;
        push.valid  = 1'b1;
        push.evt.cp = cont;
      end else if (in_last) begin
        rem_nxt     = 2'd0;
        part_nxt    = '0;
        push.valid  = 1'b1;
        push.evt.st = u2u_pkg::ST_TRUNC;
      end else begin
        rem_nxt  = rem_dec;
        part_nxt = cont;
      end
    end
  end

endmodule

FILE: hw/rtl/u2u_queue.sv
// ----------------------------------------------------------------------------
// UTF-8 transcoder event queue
// Short FIFO of decoded events between the front and the back.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_utf32_transcoder_core_macros.svh"

module u2u_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  u2u_pkg::evt_push_t   push,
  input  logic                 pop,
  output u2u_pkg::queue_stat_t stat
);

  u2u_pkg::evt_t                mem_r [u2u_pkg::QUEUE_DEPTH];
  logic [u2u_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [u2u_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [u2u_pkg::QUEUE_CW-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == u2u_pkg::QUEUE_CW'(u2u_pkg::QUEUE_DEPTH));
  assign stat.head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid) begin
      wr_ptr_nxt = wr_ptr_r + u2u_pkg::QUEUE_AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + u2u_pkg::QUEUE_AW'(1);
    end
    if (push.valid && !pop) begin
      count_nxt = count_r + u2u_pkg::QUEUE_CW'(1);
    end else if (!push.valid && pop) begin
      count_nxt = count_r - u2u_pkg::QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.evt;
    end
  end

  `U2U_ASSERT(a_no_push_full, !(push.valid && stat.full && !pop), "push into full queue")
  `U2U_ASSERT(a_no_pop_empty, !(pop && stat.empty), "pop from empty queue")
  `U2U_ASSERT(a_ptr_count, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r), "queue pointers disagree")

endmodule

FILE: hw/rtl/u2u_back.sv
// ----------------------------------------------------------------------------
// UTF-8 transcoder back
// Pops decoded events and drives result transfers, splitting surrogate pairs.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_utf32_transcoder_core_macros.svh"

module u2u_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  u2u_pkg::fmt_t            fmt,
  input  u2u_pkg::queue_stat_t     stat,
  output logic                     pop,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [u2u_pkg::CP_W-1:0] out_unit,
  output u2u_pkg::status_t         out_status,
  output logic                     out_tlast
);

  logic                     valid_r, valid_nxt;
  logic                     pend_r, pend_nxt;
  logic [15:0]              lo_r, lo_nxt;
  logic [u2u_pkg::CP_W-1:0] unit_r, unit_nxt;
  u2u_pkg::status_t         status_r, status_nxt;
  logic                     last_r, last_nxt;
  logic                     load_ok;
  logic                     pair;
  logic [15:0]              hi_unit;
  logic [15:0]              lo_unit;

  assign load_ok = !valid_r || out_tready;
  assign pair    = (fmt == u2u_pkg::FMT_UTF16) && (stat.head.st == u2u_pkg::ST_OK) &&
                   (stat.head.cp[u2u_pkg::CP_W-1:16] != '0);
  assign hi_unit = {5'b0, stat.head.cp[u2u_pkg::CP_W-1:10]} + u2u_pkg::HI_SURR_OFFSET;
  assign lo_unit = {6'b0, stat.head.cp[9:0]} + u2u_pkg::LO_SURR_OFFSET;

  assign out_tvalid = valid_r;
  assign out_unit   = unit_r;
  assign out_status = status_r;
  assign out_tlast  = last_r;

  always_comb begin
    valid_nxt  = valid_r;
    pend_nxt   = pend_r;
    lo_nxt     = lo_r;
    unit_nxt   = unit_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    pop        = 1'b0;
    if (load_ok) begin
      if (pend_r) begin
        valid_nxt  = 1'b1;
        pend_nxt   = 1'b0;
        unit_nxt   = {{(u2u_pkg::CP_W-16){1'b0}}, lo_r};
        status_nxt = u2u_pkg::ST_OK;
        last_nxt   = 1'b1;
      end else if (!stat.empty) begin
        pop        = 1'b1;
        valid_nxt  = 1'b1;
        status_nxt = stat.head.st;
        if (pair) begin
          pend_nxt = 1'b1;
          lo_nxt   = lo_unit;
          unit_nxt = {{(u2u_pkg::CP_W-16){1'b0}}, hi_unit};
          last_nxt = 1'b0;
        end else begin
          unit_nxt = stat.head.cp;
          last_nxt = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    unit_r   <= unit_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  `U2U_ASSERT(a_pend_high, pend_r |-> (valid_r && !last_r), "low half pending without high half")
  `U2U_ASSERT(a_err_zero, (valid_r && status_r != u2u_pkg::ST_OK) |-> (unit_r == '0), "error result carries data")
  `U2U_ASSERT(a_no_pop_pend, pend_r |-> !pop, "pop while low half pending")

endmodule

FILE: hw/rtl/utf8_to_utf16_utf32_transcoder_core.sv
// Path: a byte that completes a code point or an error is written into the queue on its transfer,
// then into the output register; a surrogate pair gives its low unit once the high unit is taken.
// Throughput: one byte per cycle while the queue is not full; the back emits one result per cycle
// while the receiver takes it, and each surrogate pair is two results, so events back up in the 4-entry queue.
// Reset: synchronous, active low; clears sequence state, queue, output stage, output_format.
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16/UTF-32 transcoder core
// Stream in text bytes, stream out code units; APB-style format register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_utf32_transcoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_unit, [22:21] status, [23] zero
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  u2u_pkg::fmt_t            fmt_r, fmt_nxt;
  u2u_pkg::evt_push_t       push;
  u2u_pkg::queue_stat_t     stat;
  logic                     pop;
  logic                     in_fire;
  logic [u2u_pkg::CP_W-1:0] out_unit;
  u2u_pkg::status_t         out_status;

  assign cfg_pready = 1'b1;
  assign in_tready  = !stat.full;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tdata  = {1'b0, out_status, out_unit};

  always_comb begin
    fmt_nxt = fmt_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr == u2u_pkg::REG_OUTPUT_FORMAT) begin
      fmt_nxt = u2u_pkg::fmt_t'(cfg_pwdata[0]);
    end
    cfg_prdata = '0;
    if (cfg_paddr == u2u_pkg::REG_OUTPUT_FORMAT) begin
      cfg_prdata = {31'b0, fmt_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= u2u_pkg::FMT_UTF16;
    end else begin
      fmt_r <= fmt_nxt;
    end
  end

  u2u_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push)
  );

  u2u_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .stat  (stat)
  );

  u2u_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fmt        (fmt_r),
    .stat       (stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_unit   (out_unit),
    .out_status (out_status),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: tb/utf8_to_utf16_utf32_transcoder_core_test.sv
// ----------------------------------------------------------------------------
// UTF-8 transcoder core testbench
// Streams UTF-8 bytes through the core: first a short table of known lead,
// continuation, error and end-of-text cases, then random well-formed runs
// mixed with noise and broken runs. Both output formats are covered under
// several sender and receiver idling patterns. Every result is checked
// against the table or an in-bench decoder.
// ----------------------------------------------------------------------------
module utf8_to_utf16_utf32_transcoder_core_test;

  localparam int          QUIET_LIMIT  = 5000;
  localparam int          PHASE_RUNS   = 40;
  localparam logic [2:0]  FMT_ADDR     = 3'(u2u_pkg::REG_OUTPUT_FORMAT << 2);

  typedef struct packed {
    logic [u2u_pkg::CP_W-1:0] unit;
    u2u_pkg::status_t         st;
    logic                     last;
  } unit_exp_t;

  typedef struct {
    logic [7:0]               b;
    logic                     eot;
    bit                       known;
    logic [u2u_pkg::CP_W-1:0] unit;
    u2u_pkg::status_t         st;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  utf8_to_utf16_utf32_transcoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder state
  u2u_pkg::fmt_t            fmt_now;
  logic [1:0]               open_left;
  logic [u2u_pkg::CP_W-1:0] cp_acc;

  unit_exp_t pending_units[$];
  unit_exp_t fresh_units[$];
  unit_exp_t want;

  int fail_count;
  int mismatch_count = 0;
  int bytes_sent;
  int units_seen = 0;
  int fmt_writes;
  int quiet_cycles = 0;
  int sender_idle_pct;
  int sink_stall_pct;

  row_t plan [26] = '{
    '{8'h00, 1'b0, 1'b1, 21'h00, u2u_pkg::ST_OK},
    '{8'h7F, 1'b1, 1'b1, 21'h7F, u2u_pkg::ST_OK},
    '{8'h80, 1'b0, 1'b1, 21'h00, u2u_pkg::ST_BAD_LEAD},
    '{8'hF8, 1'b0, 1'b1, 21'h00, u2u_pkg::ST_BAD_LEAD},
    '{8'hFF, 1'b1, 1'b1, 21'h00, u2u_pkg::ST_BAD_LEAD},
    '{8'hC3, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hA9, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hE2, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h82, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hAC, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hF0, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h9F, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h98, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h80, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hC3, 1'b1, 1'b1, 21'h00, u2u_pkg::ST_TRUNC},
    '{8'hE2, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h41, 1'b0, 1'b1, 21'h00, u2u_pkg::ST_BAD_CONT},
    '{8'hF4, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'h8F, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hBF, 1'b1, 1'b1, 21'h00, u2u_pkg::ST_TRUNC},
    '{8'hE2, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hFF, 1'b1, 1'b1, 21'h00, u2u_pkg::ST_BAD_CONT},
    '{8'hF7, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hBF, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hBF, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK},
    '{8'hBF, 1'b0, 1'b0, 21'h00, u2u_pkg::ST_OK}
  };

  task automatic push_unit(input logic [u2u_pkg::CP_W-1:0] unit, input u2u_pkg::status_t st,
                           input logic last);
    unit_exp_t u;
    u.unit = unit;
    u.st   = st;
    u.last = last;
    fresh_units.push_back(u);
  endtask

  task automatic emit_code_point(input logic [u2u_pkg::CP_W-1:0] cp);
    logic [15:0] hi;
    logic [15:0] lo;
    hi = 16'(cp >> 10) + u2u_pkg::HI_SURR_OFFSET;
    lo = 16'(cp[9:0]) + u2u_pkg::LO_SURR_OFFSET;
    if (fmt_now == u2u_pkg::FMT_UTF32 || cp < 21'h10000) begin
      push_unit(cp, u2u_pkg::ST_OK, 1'b1);
    end else begin
      push_unit(21'(hi), u2u_pkg::ST_OK, 1'b0);
      push_unit(21'(lo), u2u_pkg::ST_OK, 1'b1);
    end
  endtask

  task automatic decode_text_byte(input logic [7:0] b, input logic eot);
    int n;
    logic [u2u_pkg::CP_W-1:0] cp;
    fresh_units.delete();
    if (open_left == 2'd0) begin
      n = 0;
      while (n < 8 && b[7-n]) n++;
      if (n == 0) begin
        emit_code_point(21'(b));
      end else if (n == 1 || n > 4) begin
        push_unit('0, u2u_pkg::ST_BAD_LEAD, 1'b1);
      end else begin
        case (n)
          2: cp_acc = 21'(b[4:0]);
          3: cp_acc = 21'(b[3:0]);
          default: cp_acc = 21'(b[2:0]);
        endcase
        open_left = 2'(n - 1);
        if (eot) begin
          open_left = 2'd0;
          cp_acc    = '0;
          push_unit('0, u2u_pkg::ST_TRUNC, 1'b1);
        end
      end
    end else if (b[7:6] != 2'b10) begin
      open_left = 2'd0;
      cp_acc    = '0;
      push_unit('0, u2u_pkg::ST_BAD_CONT, 1'b1);
    end else begin
      cp_acc    = {cp_acc[u2u_pkg::CP_W-7:0], b[5:0]};
      open_left = open_left - 2'd1;
      if (open_left == 2'd0) begin
        cp     = cp_acc;
        cp_acc = '0;
        emit_code_point(cp);
      end else if (eot) begin
        open_left = 2'd0;
        cp_acc    = '0;
        push_unit('0, u2u_pkg::ST_TRUNC, 1'b1);
      end
    end
  endtask

  // call at a falling edge; returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic eot, input bit known = 1'b0,
                           input logic [u2u_pkg::CP_W-1:0] unit = '0,
                           input u2u_pkg::status_t st = u2u_pkg::ST_OK);
    unit_exp_t u;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eot;
    do @(posedge clk); while (!in_tready);
    decode_text_byte(b, eot);
    if (known) begin
      u.unit = unit;
      u.st   = st;
      u.last = 1'b1;
      pending_units.push_back(u);
    end else begin
      foreach (fresh_units[i]) pending_units.push_back(fresh_units[i]);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // well-formed runs with random payload, plus cut runs and raw noise
  task automatic send_random_run();
    int len;
    int cut;
    int k;
    logic [7:0] b;
    logic eot;
    if ($urandom_range(99) < 20) begin
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end else begin
      len = $urandom_range(1, 4);
      cut = len;
      if (len > 1 && $urandom_range(99) < 12) cut = $urandom_range(1, len - 1);
      for (k = 0; k < cut; k++) begin
        if (k > 0) begin
          b = 8'h80 | 8'($urandom_range(63));
        end else begin
          case (len)
            1: b = 8'($urandom_range(127));
            2: b = 8'hC0 | 8'($urandom_range(31));
            3: b = 8'hE0 | 8'($urandom_range(15));
            default: b = 8'hF0 | 8'($urandom_range(7));
          endcase
        end
        eot = (k == cut - 1) && ($urandom_range(99) < 8);
        send_byte(b, eot);
      end
    end
  endtask

  // call at a falling edge; holds the sender until every result has come
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_units.size() != 0);
  endtask

  task automatic write_format(input u2u_pkg::fmt_t f);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= FMT_ADDR;
    cfg_pwdata  <= 32'(f);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    fmt_now = f;
    fmt_writes++;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== 32'(f)) begin
      $error("output_format readback: expected %h, got %h", 32'(f), cfg_prdata);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_units.size() == 0) begin
        $error("unexpected result: code_unit=%h status=%0d last_of_run=%b",
               out_tdata[20:0], out_tdata[22:21], out_tlast);
        mismatch_count++;
      end else begin
        want = pending_units.pop_front();
        units_seen++;
        if (out_tdata[20:0] !== want.unit) begin
          $error("code_unit: expected %h, got %h", want.unit, out_tdata[20:0]);
          mismatch_count++;
        end
        if (out_tdata[22:21] !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, out_tdata[22:21]);
          mismatch_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_tlast);
          mismatch_count++;
        end
        if (out_tdata[23] !== 1'b0) begin
          $error("pad bit: expected 0, got %b", out_tdata[23]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, pending_units.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int p;
    int i;
    int mode;
    rst_n           <= 1'b0;
    in_tvalid       <= 1'b0;
    in_tdata        <= '0;
    in_tlast        <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    fmt_now         = u2u_pkg::FMT_UTF16;
    open_left       = 2'd0;
    cp_acc          = '0;
    fail_count      = 0;
    bytes_sent      = 0;
    fmt_writes      = 0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r]) begin
      send_byte(plan[r].b, plan[r].eot, plan[r].known, plan[r].unit, plan[r].st);
    end

    for (p = 0; p < 8; p++) begin
      drain_results();
      repeat (4) @(negedge clk);
      write_format(u2u_pkg::fmt_t'((p + 1) % 2));
      mode = p / 2;
      sender_idle_pct = (mode == 1) ? 45 : (mode == 3) ? 16 : 0;
      sink_stall_pct  = (mode == 2) ? 45 : (mode == 3) ? 16 : 0;
      i = 0;
      while (i < PHASE_RUNS) begin
        if (i >= PHASE_RUNS / 2 && i < PHASE_RUNS / 2 + 4 && p % 3 == 0) begin
          drain_results();
          i = PHASE_RUNS / 2 + 4;
        end
        send_random_run();
        i++;
      end
      // close any open run before the format changes
      send_byte(8'h0A, 1'b1);
    end

    drain_results();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    repeat (12) @(negedge clk);
    if (pending_units.size() != 0) begin
      $error("%0d expected results never arrived", pending_units.size());
      fail_count++;
    end
    $display("run: %0d text bytes sent, %0d results checked", bytes_sent, units_seen);
    $display("run: %0d format writes, UTF-16 and UTF-32, four idle/stall patterns", fmt_writes);
    if (fail_count == 0 && mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
